@@ rtl/i2cm_pkg.sv @@
// shared types, codes and reset values for the i2c register access master
package i2cm_pkg;

    localparam int unsigned HALF_W = 8;
    localparam int unsigned TMO_W  = 10;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 8'd36;
    localparam logic [TMO_W-1:0]  ACK_TIMEOUT_RESET = 10'd255;

    // configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // command codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_BURST = 2'd3;

    // completion status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BUS_BUSY = 2'd1;
    localparam logic [1:0] STATUS_BUS_ERR  = 2'd2;
    localparam logic [1:0] STATUS_NO_ACK   = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] slave_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] burst_length;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic [7:0] read_data;
        logic       data_valid;
        logic       last_byte;
        logic       done_res;
        logic [1:0] status;
    } t_result;

endpackage

@@ rtl/i2cm_core.sv @@
// bus phase sequencer: advances one tick per accepted word and forms its result
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_item            i_item,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    output t_result          o_result
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_REL, PH_ST_LOW, PH_ST_HOLD,
        PH_TX_L1, PH_TX_L2, PH_TX_H,
        PH_ACK_L1, PH_ACK_L2, PH_ACK_H, PH_ACK_END,
        PH_RX_L, PH_RX_H,
        PH_MACK_L1, PH_MACK_L2, PH_MACK_H, PH_MACK_L3,
        PH_SP1, PH_SP2, PH_SP3, PH_SP4
    } t_phase;

    // which byte is on the wire while sending
    localparam logic [7:0] BYTE_ADDR_W = 8'd0;
    localparam logic [7:0] BYTE_REG    = 8'd1;
    localparam logic [7:0] BYTE_DATA   = 8'd2;
    localparam logic [7:0] BYTE_ADDR_R = 8'd3;

    logic [HALF_W-1:0] r_half;
    logic [TMO_W-1:0]  r_ack_to;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_tick, n_tick;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_bytes, n_bytes;
    logic [9:0]  r_wait, n_wait;
    logic [1:0]  r_func, n_func;
    logic [6:0]  r_slave, n_slave;
    logic [7:0]  r_reg, n_reg;
    logic [7:0]  r_data, n_data;
    logic [7:0]  r_len, n_len;
    logic [1:0]  r_status, n_status;

    logic        rx_valid;
    logic        rx_last;
    logic [7:0]  rx_data;
    logic [7:0]  half_eff;
    logic        phase_end;
    logic [7:0]  bytes_dec;
    logic        ackbit;
    logic        done;

    assign half_eff  = (r_half == 8'd0) ? 8'd1 : r_half;
    assign phase_end = !(({1'b0, r_tick} + 9'd1) < {1'b0, half_eff});
    assign bytes_dec = (r_bytes != 8'd0) ? (r_bytes - 8'd1) : 8'd0;

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_bytes  = r_bytes;
        n_wait   = r_wait;
        n_func   = r_func;
        n_slave  = r_slave;
        n_reg    = r_reg;
        n_data   = r_data;
        n_len    = r_len;
        n_status = r_status;
        rx_valid = 1'b0;
        rx_last  = 1'b0;
        rx_data  = 8'd0;
        if (r_phase == PH_IDLE) begin
            if (i_item.func != FUNC_TICK) begin
                n_func   = i_item.func;
                n_slave  = i_item.slave_addr;
                n_reg    = i_item.reg_addr;
                n_data   = i_item.write_data;
                n_len    = i_item.burst_length;
                n_status = STATUS_OK;
                n_tick   = 8'd0;
                n_bit    = 4'd0;
                n_shift  = 8'd0;
                n_bytes  = 8'd0;
                n_wait   = 10'd0;
                n_phase  = PH_ST_REL;
            end
        end else if (!phase_end) begin
            n_tick = r_tick + 8'd1;
        end else begin
            n_tick = 8'd0;
            case (r_phase)
                PH_ST_REL: begin
                    if (!i_item.sda_in) begin
                        n_status = STATUS_BUS_BUSY;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_phase = PH_ST_LOW;
                    end
                end
                PH_ST_LOW: begin
                    if (i_item.sda_in) begin
                        n_status = STATUS_BUS_ERR;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_phase = PH_ST_HOLD;
                    end
                end
                PH_ST_HOLD: begin
                    // read bit set only for the address after a repeated start
                    n_shift = {r_slave, (r_bytes == BYTE_ADDR_R)};
                    n_bit   = 4'd0;
                    n_phase = PH_TX_L1;
                end
                PH_TX_L1: n_phase = PH_TX_L2;
                PH_TX_L2: n_phase = PH_TX_H;
                PH_TX_H: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = r_bit + 4'd1;
                    if (n_bit >= 4'd8) begin
                        n_wait  = 10'd0;
                        n_phase = PH_ACK_L1;
                    end else begin
                        n_phase = PH_TX_L1;
                    end
                end
                PH_ACK_L1: n_phase = PH_ACK_L2;
                PH_ACK_L2: n_phase = PH_ACK_H;
                PH_ACK_H: begin
                    if (!i_item.sda_in) begin
                        n_phase = PH_ACK_END;
                    end else if (r_wait >= r_ack_to) begin
                        n_status = STATUS_NO_ACK;
                        n_phase  = PH_SP1;
                    end else begin
                        n_wait = r_wait + 10'd1;
                    end
                end
                PH_ACK_END: begin
                    if (r_bytes == BYTE_ADDR_W) begin
                        n_bytes = BYTE_REG;
                        n_shift = r_reg;
                        n_bit   = 4'd0;
                        n_phase = PH_TX_L1;
                    end else if (r_bytes == BYTE_REG) begin
                        if (r_func == FUNC_WRITE) begin
                            n_bytes = BYTE_DATA;
                            n_shift = r_data;
                            n_bit   = 4'd0;
                            n_phase = PH_TX_L1;
                        end else begin
                            n_bytes = BYTE_ADDR_R;
                            n_phase = PH_ST_REL;
                        end
                    end else if (r_bytes == BYTE_ADDR_R) begin
                        n_bytes = (r_func == FUNC_BURST) ? r_len : 8'd1;
                        n_shift = 8'd0;
                        n_bit   = 4'd0;
                        n_phase = (n_bytes == 8'd0) ? PH_SP1 : PH_RX_L;
                    end else begin
                        n_phase = PH_SP1;
                    end
                end
                PH_RX_L: n_phase = PH_RX_H;
                PH_RX_H: begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_bit   = r_bit + 4'd1;
                    if (n_bit >= 4'd8) begin
                        rx_valid = 1'b1;
                        rx_data  = n_shift;
                        rx_last  = (r_bytes == 8'd1);
                        n_phase  = PH_MACK_L1;
                    end else begin
                        n_phase = PH_RX_L;
                    end
                end
                PH_MACK_L1: n_phase = PH_MACK_L2;
                PH_MACK_L2: n_phase = PH_MACK_H;
                PH_MACK_H:  n_phase = PH_MACK_L3;
                PH_MACK_L3: begin
                    n_bytes = bytes_dec;
                    if (bytes_dec == 8'd0) begin
                        n_phase = PH_SP1;
                    end else begin
                        n_shift = 8'd0;
                        n_bit   = 4'd0;
                        n_phase = PH_RX_L;
                    end
                end
                PH_SP1: n_phase = PH_SP2;
                PH_SP2: n_phase = PH_SP3;
                PH_SP3: n_phase = PH_SP4;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // line drive follows the phase after this tick's update
    assign ackbit = !(n_bytes > 8'd1);
    assign done   = (r_phase != PH_IDLE) && (n_phase == PH_IDLE);

    always_comb begin
        case (n_phase)
            PH_ST_LOW, PH_ST_HOLD: begin
                o_result.scl_out = 1'b1;
                o_result.sda_out = 1'b0;
            end
            PH_TX_L1, PH_TX_L2: begin
                o_result.scl_out = 1'b0;
                o_result.sda_out = n_shift[7];
            end
            PH_TX_H: begin
                o_result.scl_out = 1'b1;
                o_result.sda_out = n_shift[7];
            end
            PH_ACK_L1, PH_ACK_L2, PH_ACK_END, PH_RX_L, PH_MACK_L1, PH_SP1: begin
                o_result.scl_out = 1'b0;
                o_result.sda_out = 1'b1;
            end
            PH_MACK_L2, PH_MACK_L3: begin
                o_result.scl_out = 1'b0;
                o_result.sda_out = ackbit;
            end
            PH_MACK_H: begin
                o_result.scl_out = 1'b1;
                o_result.sda_out = ackbit;
            end
            PH_SP2: begin
                o_result.scl_out = 1'b0;
                o_result.sda_out = 1'b0;
            end
            PH_SP3: begin
                o_result.scl_out = 1'b1;
                o_result.sda_out = 1'b0;
            end
            default: begin
                o_result.scl_out = 1'b1;
                o_result.sda_out = 1'b1;
            end
        endcase
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.read_data  = rx_data;
        o_result.data_valid = rx_valid;
        o_result.last_byte  = rx_last;
        o_result.done_res   = done;
        o_result.status     = done ? n_status : STATUS_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half   <= HALF_PERIOD_RESET;
            r_ack_to <= ACK_TIMEOUT_RESET;
            r_phase  <= PH_IDLE;
            r_tick   <= 8'd0;
            r_bit    <= 4'd0;
            r_shift  <= 8'd0;
            r_bytes  <= 8'd0;
            r_wait   <= 10'd0;
            r_func   <= FUNC_TICK;
            r_slave  <= 7'd0;
            r_reg    <= 8'd0;
            r_data   <= 8'd0;
            r_len    <= 8'd0;
            r_status <= STATUS_OK;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_HALF_PERIOD: r_half   <= i_cfg_wr_data[HALF_W-1:0];
                    CFG_ACK_TIMEOUT: r_ack_to <= i_cfg_wr_data[TMO_W-1:0];
                    default: ;
                endcase
            end
            if (i_step) begin
                r_phase  <= n_phase;
                r_tick   <= n_tick;
                r_bit    <= n_bit;
                r_shift  <= n_shift;
                r_bytes  <= n_bytes;
                r_wait   <= n_wait;
                r_func   <= n_func;
                r_slave  <= n_slave;
                r_reg    <= n_reg;
                r_data   <= n_data;
                r_len    <= n_len;
                r_status <= n_status;
            end
        end
    end

endmodule

@@ rtl/i2cm_skid.sv @@
// two-entry output buffer so the input stall comes straight from a register
module i2cm_skid
    import i2cm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_word,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_word,
    input  logic    i_stall
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take    = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_valid) begin
                // skid is empty whenever a word comes in
                if (!r_out_valid || take) begin
                    r_out       <= i_word;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= i_word;
                    r_skid_valid <= 1'b1;
                end
            end else if (take) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

endmodule

@@ rtl/i2c_master_register_access.sv @@
// top level of the i2c register access master
//
// each input word is one tick of the bus timing: it carries a command
// (tick only, single write, single read, burst read), its operands and the
// sampled sda level. a command is latched only while the master is idle;
// later words just advance the bus phases. every accepted word gives one
// result word with the scl/sda drive, busy, received byte and done status.
// each result word is formed from its accepted input word and registered
// in the output buffer. throughput: one word per cycle unless stalled,
// set by the single phase update between state and output registers.
// the output side holds two words; o_in_stall rises once both are taken
// up while the receiver stalls, and falls the cycle after one leaves.
// configuration: index 0 is ticks per scl phase, index 1 is the ack
// timeout in scl phases; write them only while no command is running.
// reset (synchronous, active low) returns to idle with 36 ticks per phase
// and a timeout of 255, and empties the output buffer.
module i2c_master_register_access
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [6:0] i_slave_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_burst_length,
    input  logic       i_sda_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic [7:0] o_read_data,
    output logic       o_data_valid,
    output logic       o_last_byte,
    output logic       o_done_res,
    output logic [1:0] o_status
);

    t_item   item;
    t_result result;
    t_result out_word;
    logic    accept;
    logic    full;

    assign accept     = i_in_valid && !full;
    assign o_in_stall = full;

    assign item.func         = i_func;
    assign item.slave_addr   = i_slave_addr;
    assign item.reg_addr     = i_reg_addr;
    assign item.write_data   = i_write_data;
    assign item.burst_length = i_burst_length;
    assign item.sda_in       = i_sda_in;

    i2cm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (accept),
        .i_item        (item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (result)
    );

    i2cm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_word  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_word  (out_word),
        .i_stall (i_out_stall)
    );

    assign o_scl_out    = out_word.scl_out;
    assign o_sda_out    = out_word.sda_out;
    assign o_busy_res   = out_word.busy_res;
    assign o_read_data  = out_word.read_data;
    assign o_data_valid = out_word.data_valid;
    assign o_last_byte  = out_word.last_byte;
    assign o_done_res   = out_word.done_res;
    assign o_status     = out_word.status;

endmodule

@@ verif/tb.sv @@
// testbench for the i2c register access master: tick-level predictor with a cooperative slave
module tb
    import i2cm_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_REL, PH_ST_LOW, PH_ST_HOLD, PH_TX_L1, PH_TX_L2, PH_TX_H,
        PH_ACK_L1, PH_ACK_L2, PH_ACK_H, PH_ACK_END, PH_RX_L, PH_RX_H,
        PH_MACK_L1, PH_MACK_L2, PH_MACK_H, PH_MACK_L3,
        PH_SP1, PH_SP2, PH_SP3, PH_SP4
    } t_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic                  i_cfg_idx = CFG_HALF_PERIOD;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_func = FUNC_TICK;
    logic [6:0]            i_slave_addr = '0;
    logic [7:0]            i_reg_addr = '0;
    logic [7:0]            i_write_data = '0;
    logic [7:0]            i_burst_length = '0;
    logic                  i_sda_in = 1'b1;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_scl_out;
    logic                  o_sda_out;
    logic                  o_busy_res;
    logic [7:0]            o_read_data;
    logic                  o_data_valid;
    logic                  o_last_byte;
    logic                  o_done_res;
    logic [1:0]            o_status;

    // predicted master state and configuration
    t_phase      ph = PH_IDLE;
    logic [7:0]  tick_cnt = '0;
    logic [3:0]  bit_cnt = '0;
    logic [7:0]  shreg = '0;
    logic [7:0]  byte_no = '0;
    logic [9:0]  wait_cnt = '0;
    logic [1:0]  cmd_func = FUNC_TICK;
    logic [6:0]  cmd_slave = '0;
    logic [7:0]  cmd_reg = '0;
    logic [7:0]  cmd_data = '0;
    logic [7:0]  cmd_len = '0;
    logic [1:0]  res_status = STATUS_OK;
    logic [7:0]  half_cfg = HALF_PERIOD_RESET;
    logic [9:0]  tmo_cfg = ACK_TIMEOUT_RESET;

    t_result     expected_bus[$];
    int          words_sent = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle_pct = 29;
    int          recv_idle_pct = 53;

    // slave behaviour knobs, in percent, plus a repeated-start-only flag
    int          busy_pct = 0;
    int          err_pct = 0;
    int          nack_pct = 0;
    logic        restart_only = 1'b0;

    i2c_master_register_access uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("i2c_master_register_access: mismatch");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    function automatic bit hit(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic void load_tx_byte(logic [7:0] b);
        shreg = b;
        bit_cnt = '0;
        ph = PH_TX_L1;
    endfunction

    // one tick of the master: returns the word it should put out
    function automatic t_result bus_tick(t_item w);
        t_result r;
        logic    was_busy;
        logic    ackbit;
        logic [7:0] h;
        r = '0;
        was_busy = (ph != PH_IDLE);
        if (!was_busy) begin
            if (w.func != FUNC_TICK) begin
                cmd_func = w.func;
                cmd_slave = w.slave_addr;
                cmd_reg = w.reg_addr;
                cmd_data = w.write_data;
                cmd_len = w.burst_length;
                res_status = STATUS_OK;
                tick_cnt = '0;
                bit_cnt = '0;
                shreg = '0;
                byte_no = '0;
                wait_cnt = '0;
                ph = PH_ST_REL;
            end
        end else begin
            h = (half_cfg == 8'd0) ? 8'd1 : half_cfg;
            if ({1'b0, tick_cnt} + 9'd1 < {1'b0, h}) begin
                tick_cnt++;
            end else begin
                tick_cnt = '0;
                case (ph)
                    PH_ST_REL: begin
                        if (!w.sda_in) begin
                            res_status = STATUS_BUS_BUSY;
                            ph = PH_IDLE;
                        end else ph = PH_ST_LOW;
                    end
                    PH_ST_LOW: begin
                        if (w.sda_in) begin
                            res_status = STATUS_BUS_ERR;
                            ph = PH_IDLE;
                        end else ph = PH_ST_HOLD;
                    end
                    PH_ST_HOLD: load_tx_byte({cmd_slave, (byte_no == 8'd3)});
                    PH_TX_L1: ph = PH_TX_L2;
                    PH_TX_L2: ph = PH_TX_H;
                    PH_TX_H: begin
                        shreg = shreg << 1;
                        bit_cnt++;
                        if (bit_cnt >= 4'd8) begin
                            wait_cnt = '0;
                            ph = PH_ACK_L1;
                        end else ph = PH_TX_L1;
                    end
                    PH_ACK_L1: ph = PH_ACK_L2;
                    PH_ACK_L2: ph = PH_ACK_H;
                    PH_ACK_H: begin
                        if (!w.sda_in) ph = PH_ACK_END;
                        else if (wait_cnt >= tmo_cfg) begin
                            res_status = STATUS_NO_ACK;
                            ph = PH_SP1;
                        end else wait_cnt++;
                    end
                    PH_ACK_END: begin
                        if (byte_no == 8'd0) begin
                            byte_no = 8'd1;
                            load_tx_byte(cmd_reg);
                        end else if (byte_no == 8'd1) begin
                            if (cmd_func == FUNC_WRITE) begin
                                byte_no = 8'd2;
                                load_tx_byte(cmd_data);
                            end else begin
                                // repeated start before the read address
                                byte_no = 8'd3;
                                ph = PH_ST_REL;
                            end
                        end else if (byte_no == 8'd3) begin
                            byte_no = (cmd_func == FUNC_BURST) ? cmd_len : 8'd1;
                            shreg = '0;
                            bit_cnt = '0;
                            ph = (byte_no == 8'd0) ? PH_SP1 : PH_RX_L;
                        end else ph = PH_SP1;
                    end
                    PH_RX_L: ph = PH_RX_H;
                    PH_RX_H: begin
                        shreg = {shreg[6:0], w.sda_in};
                        bit_cnt++;
                        if (bit_cnt >= 4'd8) begin
                            r.data_valid = 1'b1;
                            r.read_data = shreg;
                            r.last_byte = (byte_no == 8'd1);
                            ph = PH_MACK_L1;
                        end else ph = PH_RX_L;
                    end
                    PH_MACK_L1: ph = PH_MACK_L2;
                    PH_MACK_L2: ph = PH_MACK_H;
                    PH_MACK_H: ph = PH_MACK_L3;
                    PH_MACK_L3: begin
                        if (byte_no > 8'd0) byte_no--;
                        if (byte_no == 8'd0) ph = PH_SP1;
                        else begin
                            shreg = '0;
                            bit_cnt = '0;
                            ph = PH_RX_L;
                        end
                    end
                    PH_SP1: ph = PH_SP2;
                    PH_SP2: ph = PH_SP3;
                    PH_SP3: ph = PH_SP4;
                    default: ph = PH_IDLE;
                endcase
            end
        end

        // master ack is low while more bytes follow, nack after the last
        ackbit = (byte_no > 8'd1) ? 1'b0 : 1'b1;
        case (ph)
            PH_ST_LOW, PH_ST_HOLD: {r.scl_out, r.sda_out} = 2'b10;
            PH_TX_L1, PH_TX_L2: {r.scl_out, r.sda_out} = {1'b0, shreg[7]};
            PH_TX_H: {r.scl_out, r.sda_out} = {1'b1, shreg[7]};
            PH_ACK_L1, PH_ACK_L2, PH_ACK_END, PH_RX_L, PH_MACK_L1, PH_SP1:
                {r.scl_out, r.sda_out} = 2'b01;
            PH_MACK_L2, PH_MACK_L3: {r.scl_out, r.sda_out} = {1'b0, ackbit};
            PH_MACK_H: {r.scl_out, r.sda_out} = {1'b1, ackbit};
            PH_SP2: {r.scl_out, r.sda_out} = 2'b00;
            PH_SP3: {r.scl_out, r.sda_out} = 2'b10;
            default: {r.scl_out, r.sda_out} = 2'b11;
        endcase
        r.busy_res = (ph != PH_IDLE);
        r.done_res = was_busy && (ph == PH_IDLE);
        r.status = r.done_res ? res_status : STATUS_OK;
        return r;
    endfunction

    // sda level a cooperating slave would present in the current phase
    function automatic logic slave_sda();
        logic armed;
        armed = (byte_no == 8'd3) || !restart_only;
        case (ph)
            PH_ST_REL: return !(armed && hit(busy_pct));
            PH_ST_LOW: return armed && hit(err_pct);
            PH_ACK_H: return hit(nack_pct);
            default: return 1'($urandom_range(1, 0));
        endcase
    endfunction

    function automatic t_item random_word(logic [1:0] f);
        t_item w;
        w.func = f;
        w.slave_addr = 7'($urandom);
        w.reg_addr = 8'($urandom);
        w.write_data = 8'($urandom);
        w.burst_length = 8'($urandom);
        w.sda_in = slave_sda();
        return w;
    endfunction

    function automatic void check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bus.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                want = expected_bus.pop_front();
                check_field("scl_out", want.scl_out, o_scl_out);
                check_field("sda_out", want.sda_out, o_sda_out);
                check_field("busy_res", want.busy_res, o_busy_res);
                check_field("read_data", want.read_data, o_read_data);
                check_field("data_valid", want.data_valid, o_data_valid);
                check_field("last_byte", want.last_byte, o_last_byte);
                check_field("done_res", want.done_res, o_done_res);
                check_field("status", want.status, o_status);
            end
        end
    end

    task automatic send_word(input t_item w);
        @(negedge i_clk);
        while (hit(send_idle_pct)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= w.func;
        i_slave_addr <= w.slave_addr;
        i_reg_addr <= w.reg_addr;
        i_write_data <= w.write_data;
        i_burst_length <= w.burst_length;
        i_sda_in <= w.sda_in;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_bus.push_back(bus_tick(w));
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bus.size() != 0) @(posedge i_clk);
    endtask

    // register writes only with the master idle and every word collected
    task automatic write_cfg(logic idx, logic [CFG_DATA_W-1:0] val);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wr_data <= val;
        if (idx == CFG_HALF_PERIOD) half_cfg = val[7:0];
        else tmo_cfg = val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_slave(int busy, int err, int nack, logic rs_only);
        busy_pct = busy;
        err_pct = err;
        nack_pct = nack;
        restart_only = rs_only;
    endtask

    // issue one command while idle and clock it through to completion
    task automatic run_command(logic [1:0] f, logic [6:0] sa, logic [7:0] ra,
                               logic [7:0] wd, logic [7:0] bl);
        t_item w;
        w = random_word(f);
        w.slave_addr = sa;
        w.reg_addr = ra;
        w.write_data = wd;
        w.burst_length = bl;
        send_word(w);
        while (ph != PH_IDLE) send_word(random_word(2'($urandom_range(3, 0))));
    endtask

    // refused starts keep these short while the reset phase length applies
    task automatic test_reset_config();
        set_slave(100, 0, 0, 1'b0);
        run_command(FUNC_READ, 7'h55, 8'hAA, 8'h55, 8'hFF);
        set_slave(0, 100, 0, 1'b0);
        run_command(FUNC_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'h00);
    endtask

    task automatic test_start_refusals();
        write_cfg(CFG_HALF_PERIOD, 10'd0);
        write_cfg(CFG_ACK_TIMEOUT, 10'd1);
        set_slave(100, 0, 0, 1'b0);
        run_command(FUNC_WRITE, 7'h12, 8'h34, 8'h56, 8'h01);
        set_slave(0, 100, 0, 1'b0);
        run_command(FUNC_BURST, 7'h21, 8'h43, 8'h65, 8'h02);
        // refusals on the repeated start of a read
        set_slave(100, 0, 0, 1'b1);
        run_command(FUNC_READ, 7'h3C, 8'hC3, 8'h00, 8'h01);
        set_slave(0, 100, 0, 1'b1);
        run_command(FUNC_BURST, 7'h43, 8'h3C, 8'h00, 8'h04);
    endtask

    task automatic test_transfers();
        write_cfg(CFG_HALF_PERIOD, 10'd0);
        set_slave(0, 0, 0, 1'b0);
        send_word(random_word(FUNC_TICK));
        send_word(random_word(FUNC_TICK));
        run_command(FUNC_BURST, 7'h2B, 8'h10, 8'h00, 8'h00);
        write_cfg(CFG_HALF_PERIOD, 10'd1);
        run_command(FUNC_BURST, 7'h19, 8'h01, 8'h02, 8'h03);
    endtask

    task automatic test_ack_timeout();
        write_cfg(CFG_HALF_PERIOD, 10'd1);
        write_cfg(CFG_ACK_TIMEOUT, 10'd1);
        set_slave(0, 0, 100, 1'b0);
        run_command(FUNC_WRITE, 7'h0F, 8'hF0, 8'h0F, 8'h00);
        write_cfg(CFG_ACK_TIMEOUT, 10'd40);
        run_command(FUNC_READ, 7'h70, 8'h07, 8'hF0, 8'h00);
        // late acks that arrive inside the timeout
        write_cfg(CFG_ACK_TIMEOUT, 10'd3);
        set_slave(0, 0, 50, 1'b0);
        run_command(FUNC_WRITE, 7'h32, 8'hCD, 8'h32, 8'h00);
    endtask

    task automatic pick_config();
        write_cfg(CFG_HALF_PERIOD,
                  hit(90) ? 10'($urandom_range(1, 0)) : 10'($urandom_range(3, 2)));
        write_cfg(CFG_ACK_TIMEOUT,
                  hit(90) ? 10'($urandom_range(6, 1)) : 10'($urandom_range(40, 7)));
    endtask

    task automatic test_random_traffic(int n_words);
        int          stop_at;
        logic [7:0]  len;
        stop_at = words_sent + n_words;
        set_slave(4, 4, 12, 1'b0);
        pick_config();
        while (words_sent < stop_at) begin
            if (hit(15)) pick_config();
            if (hit(10)) begin
                send_word(random_word(FUNC_TICK));
            end else begin
                if (hit(10)) len = 8'd0;
                else if (hit(90)) len = 8'($urandom_range(4, 1));
                else len = 8'($urandom_range(8, 5));
                run_command(2'($urandom_range(3, 1)), 7'($urandom), 8'($urandom),
                            8'($urandom), len);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 53;
        test_reset_config();
        test_start_refusals();
        test_transfers();
        test_ack_timeout();
        test_random_traffic(100);

        send_idle_pct = 53;
        recv_idle_pct = 29;
        test_random_traffic(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100);

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && expected_bus.size() == 0) begin
            $display("i2c_master_register_access: match");
        end else begin
            $display("i2c_master_register_access: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/i2cm_pkg.sv
rtl/i2cm_core.sv
rtl/i2cm_skid.sv
rtl/i2c_master_register_access.sv
verif/tb.sv
